// ----- design/pjst_pkg.sv -----
// Shared types and codes for the priority job slot table.
`timescale 1ns / 1ps

package pjst_pkg;

  // Command codes carried by the command field.
  typedef enum logic [2:0] {
    CMD_ADD      = 3'd0,
    CMD_DISPATCH = 3'd1,
    CMD_COMPLETE = 3'd2,
    CMD_SUSPEND  = 3'd3,
    CMD_RESUME   = 3'd4,
    CMD_REMOVE   = 3'd5,
    CMD_QUERY    = 3'd6
  } cmd_t;

  // Per-slot job state codes.
  typedef enum logic [2:0] {
    SLOT_EMPTY     = 3'd0,
    SLOT_PENDING   = 3'd1,
    SLOT_RUNNING   = 3'd2,
    SLOT_SUSPENDED = 3'd3,
    SLOT_DONE      = 3'd4,
    SLOT_REMOVED   = 3'd5
  } slot_state_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BAD_ID = 2'd1,
    STATUS_FULL   = 2'd2,
    STATUS_NONE   = 2'd3
  } status_t;

  // Priority bounds applied on add.
  localparam logic [1:0] PRIO_MIN = 2'd1;
  localparam logic [1:0] PRIO_MAX = 2'd3;

  // One slot table entry as stored in the slot memory.
  typedef struct packed {
    slot_state_t st;
    logic [1:0]  prio;
  } entry_t;

  // Scan context handed to the compare unit each cycle.
  typedef struct packed {
    logic       is_add;
    logic       found;
    logic [1:0] best_prio;
  } pick_req_t;

endpackage

// ----- design/pjst_pick_unit.sv -----
// Shared compare unit that judges one scanned slot entry against the current pick.
`timescale 1ns / 1ps

module pjst_pick_unit (
  input  pjst_pkg::pick_req_t req,
  input  pjst_pkg::entry_t    entry,
  output logic                hit
);

  always_comb begin
    if (req.is_add) begin
      // Add takes the first free slot only.
      hit = !req.found &&
            (entry.st == pjst_pkg::SLOT_EMPTY || entry.st == pjst_pkg::SLOT_REMOVED);
    end else begin
      // Dispatch replaces the pick only on a strictly higher priority.
      hit = (entry.st == pjst_pkg::SLOT_PENDING) &&
            (!req.found || (entry.prio > req.best_prio));
    end
  end

endmodule

// ----- design/priority_job_slot_table_core.sv -----
// Top level of the priority job slot table: sequencer, slot memory and result register.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+---------------------------------------------
// input    | in        | in_valid, in_stall | command, slot_id, requested_priority
// output   | out       | out_valid, out_stall | status_code, result_slot, slot_state,
//          |           |                    | slot_priority
//
// Complete, suspend, resume, remove and query read the slot memory, write it back and
// then load the result register, in that order. A bad slot id skips the read and the
// write-back and goes straight to the result register. Add and dispatch scan the slot
// memory through its single read port, one entry per cycle, up to the high-water mark,
// then commit the pick and load the result register. Reset clears the sequencer, the
// high-water mark and the valid bit of the result register; the slot memory needs no
// clearing pass because no entry at or above the high-water mark is ever used. One
// item is in work at a time; in_stall is high from acceptance until the result is
// loaded into the result register, and a held result under out_stall delays both the
// load and the acceptance of the next item.

module priority_job_slot_table_core #(
  parameter int SLOTS = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] command,
  input  logic [6:0] slot_id,
  input  logic [3:0] requested_priority,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status_code,
  output logic [6:0] result_slot,
  output logic [2:0] slot_state,
  output logic [1:0] slot_priority
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_DIRECT  = 5'b00010,
    S_SCAN    = 5'b00100,
    S_COMMIT  = 5'b01000,
    S_DELIVER = 5'b10000
  } fsm_t;

  fsm_t state;
  fsm_t state_next;

  // Latched command.
  pjst_pkg::cmd_t cmd;
  logic [6:0]     id;
  logic [1:0]     prio;

  // Scan bookkeeping: the read address runs ahead of the compared entry by the read data register.
  logic [CNT_W-1:0] scan_addr;
  logic             pipe_valid;
  logic [IDX_W-1:0] pipe_idx;
  logic             found;
  logic [IDX_W-1:0] pick_idx;
  logic [1:0]       best_prio;

  // One past the highest slot ever allocated.
  logic [CNT_W-1:0] high_water;

  // Result waiting to be loaded into the output register.
  pjst_pkg::status_t     res_code;
  logic [6:0]            res_slot;
  pjst_pkg::slot_state_t res_state;
  logic [1:0]            res_prio;

  // Slot memory with registered read data.
  pjst_pkg::entry_t mem [SLOTS];
  pjst_pkg::entry_t rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  pjst_pkg::entry_t wr_data;

  logic                  accept;
  logic                  bad_id;
  logic                  add_room;
  logic [IDX_W-1:0]      add_slot;
  logic                  scan_end;
  logic                  out_load;
  logic                  hit;
  logic [1:0]            prio_clamped;
  pjst_pkg::pick_req_t   pick_req;
  pjst_pkg::slot_state_t direct_state;
  pjst_pkg::cmd_t        in_cmd;

  assign in_cmd   = pjst_pkg::cmd_t'(command);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Ids at or above the high-water mark are rejected; that also covers ids beyond SLOTS.
  assign bad_id   = CMP_W'(slot_id) >= CMP_W'(high_water);
  assign add_room = high_water < CNT_W'(SLOTS);
  assign add_slot = found ? pick_idx : high_water[IDX_W-1:0];
  assign scan_end = (scan_addr >= high_water) && !pipe_valid;
  assign out_load = (state == S_DELIVER) && (!out_valid || !out_stall);

  always_comb begin
    if (requested_priority == 4'd0) begin
      prio_clamped = pjst_pkg::PRIO_MIN;
    end else if (requested_priority > 4'(pjst_pkg::PRIO_MAX)) begin
      prio_clamped = pjst_pkg::PRIO_MAX;
    end else begin
      prio_clamped = requested_priority[1:0];
    end
  end

  assign pick_req.is_add    = (cmd == pjst_pkg::CMD_ADD);
  assign pick_req.found     = found;
  assign pick_req.best_prio = best_prio;

  pjst_pick_unit u_pick (
    .req   (pick_req),
    .entry (rd_data),
    .hit   (hit)
  );

  // State change for the single-slot commands; an unknown code acts as query.
  always_comb begin
    direct_state = rd_data.st;
    unique case (cmd)
      pjst_pkg::CMD_COMPLETE: begin
        if (rd_data.st != pjst_pkg::SLOT_REMOVED) begin
          direct_state = pjst_pkg::SLOT_DONE;
        end
      end
      pjst_pkg::CMD_SUSPEND: begin
        if (rd_data.st == pjst_pkg::SLOT_RUNNING) begin
          direct_state = pjst_pkg::SLOT_SUSPENDED;
        end
      end
      pjst_pkg::CMD_RESUME: begin
        if (rd_data.st == pjst_pkg::SLOT_SUSPENDED) begin
          direct_state = pjst_pkg::SLOT_RUNNING;
        end
      end
      pjst_pkg::CMD_REMOVE: begin
        direct_state = pjst_pkg::SLOT_REMOVED;
      end
      default: begin
        direct_state = rd_data.st;
      end
    endcase
  end

  // The read port follows the incoming slot id while idle and the scan address otherwise.
  assign rd_addr = (state == S_IDLE) ? IDX_W'(slot_id) : scan_addr[IDX_W-1:0];

  // Write port: write back a single-slot command, or commit an add or a dispatch.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = IDX_W'(id);
    wr_data = rd_data;
    if (state == S_DIRECT) begin
      wr_en        = 1'b1;
      wr_data.st   = direct_state;
      wr_data.prio = rd_data.prio;
    end else if (state == S_COMMIT) begin
      if (cmd == pjst_pkg::CMD_ADD) begin
        wr_en        = found || add_room;
        wr_addr      = add_slot;
        wr_data.st   = pjst_pkg::SLOT_PENDING;
        wr_data.prio = prio;
      end else begin
        wr_en        = found;
        wr_addr      = pick_idx;
        wr_data.st   = pjst_pkg::SLOT_RUNNING;
        wr_data.prio = best_prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == pjst_pkg::CMD_ADD || in_cmd == pjst_pkg::CMD_DISPATCH) begin
            state_next = S_SCAN;
          end else if (bad_id) begin
            state_next = S_DELIVER;
          end else begin
            state_next = S_DIRECT;
          end
        end
      end
      S_DIRECT: begin
        state_next = S_DELIVER;
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        state_next = S_DELIVER;
      end
      S_DELIVER: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      high_water <= '0;
      pipe_valid <= 1'b0;
      found      <= 1'b0;
      scan_addr  <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && accept) begin
        scan_addr  <= '0;
        pipe_valid <= 1'b0;
        found      <= 1'b0;
      end
      if (state == S_SCAN) begin
        if (scan_addr < high_water) begin
          pipe_valid <= 1'b1;
          scan_addr  <= scan_addr + CNT_W'(1);
        end else begin
          pipe_valid <= 1'b0;
        end
        if (pipe_valid && hit) begin
          found <= 1'b1;
        end
      end
      // A new slot beyond the high-water mark extends the mark.
      if (state == S_COMMIT && cmd == pjst_pkg::CMD_ADD && !found && add_room) begin
        high_water <= high_water + CNT_W'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      cmd  <= in_cmd;
      id   <= slot_id;
      prio <= prio_clamped;
      if (in_cmd != pjst_pkg::CMD_ADD && in_cmd != pjst_pkg::CMD_DISPATCH && bad_id) begin
        res_code  <= pjst_pkg::STATUS_BAD_ID;
        res_slot  <= slot_id;
        res_state <= pjst_pkg::SLOT_EMPTY;
        res_prio  <= 2'd0;
      end
    end
    if (state == S_SCAN) begin
      pipe_idx <= scan_addr[IDX_W-1:0];
      if (pipe_valid && hit) begin
        pick_idx  <= pipe_idx;
        best_prio <= rd_data.prio;
      end
    end
    if (state == S_DIRECT) begin
      res_code  <= pjst_pkg::STATUS_OK;
      res_slot  <= id;
      res_state <= direct_state;
      res_prio  <= rd_data.prio;
    end
    if (state == S_COMMIT) begin
      if (cmd == pjst_pkg::CMD_ADD) begin
        if (found || add_room) begin
          res_code  <= pjst_pkg::STATUS_OK;
          res_slot  <= 7'(add_slot);
          res_state <= pjst_pkg::SLOT_PENDING;
          res_prio  <= prio;
        end else begin
          res_code  <= pjst_pkg::STATUS_FULL;
          res_slot  <= 7'd0;
          res_state <= pjst_pkg::SLOT_EMPTY;
          res_prio  <= 2'd0;
        end
      end else begin
        if (found) begin
          res_code  <= pjst_pkg::STATUS_OK;
          res_slot  <= 7'(pick_idx);
          res_state <= pjst_pkg::SLOT_RUNNING;
          res_prio  <= best_prio;
        end else begin
          res_code  <= pjst_pkg::STATUS_NONE;
          res_slot  <= 7'd0;
          res_state <= pjst_pkg::SLOT_EMPTY;
          res_prio  <= 2'd0;
        end
      end
    end
  end

  // Output register: loads when empty or when its item is taken in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status_code   <= res_code;
      result_slot   <= res_slot;
      slot_state    <= res_state;
      slot_priority <= res_prio;
    end
  end

endmodule

// ----- design/pjst_checker.sv -----
// Port-level assertions for the priority job slot table and their bind.
`timescale 1ns / 1ps

module pjst_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status_code,
  input logic [6:0] result_slot,
  input logic [2:0] slot_state,
  input logic [1:0] slot_priority
);

  // An accepted item keeps the input closed for at least the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in consecutive cycles");

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result withdrawn");

  // Every slot reported as ok carries a stored priority of one to three.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_code == pjst_pkg::STATUS_OK) |-> (slot_priority != 2'd0))
    else $error("ok result with zero priority");

  // Full table and no pending job report an all-zero slot.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status_code == pjst_pkg::STATUS_FULL ||
                   status_code == pjst_pkg::STATUS_NONE))
    |-> (result_slot == 7'd0 && slot_state == 3'd0 && slot_priority == 2'd0))
    else $error("failed add or dispatch reports a slot");

  // A rejected id reports no state and no priority.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_code == pjst_pkg::STATUS_BAD_ID)
    |-> (slot_state == 3'd0 && slot_priority == 2'd0))
    else $error("bad id result reports slot contents");

endmodule

bind priority_job_slot_table_core pjst_checker u_pjst_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status_code   (status_code),
  .result_slot   (result_slot),
  .slot_state    (slot_state),
  .slot_priority (slot_priority)
);

// ----- verif/pjst_result_checker.sv -----
// Result checker for the priority job slot table: tracks the table and compares every result.
`timescale 1ns / 1ps

module pjst_result_checker #(
  parameter int SLOTS = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] command,
  input  logic [6:0] slot_id,
  input  logic [3:0] requested_priority,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] status_code,
  input  logic [6:0] result_slot,
  input  logic [2:0] slot_state,
  input  logic [1:0] slot_priority,
  output int         fail_count,
  output int         outstanding
);

  typedef struct packed {
    pjst_pkg::status_t     status;
    logic [6:0]            slot;
    pjst_pkg::slot_state_t st;
    logic [1:0]            prio;
  } job_result_t;

  pjst_pkg::slot_state_t job_state_q [SLOTS];
  logic [1:0]            job_prio_q  [SLOTS];
  int unsigned           high_water_q;
  job_result_t           awaited_results [$];

  // Applies one command to the tracked table and returns the result it must produce.
  function automatic job_result_t next_table_result(input logic [2:0] cmd,
                                                    input logic [6:0] id,
                                                    input logic [3:0] req);
    job_result_t           r;
    int unsigned           i;
    int unsigned           best;
    bit                    found;
    logic [1:0]            pr;
    pjst_pkg::slot_state_t st;
    r.status = pjst_pkg::STATUS_OK;
    r.slot   = '0;
    r.st     = pjst_pkg::SLOT_EMPTY;
    r.prio   = '0;
    best     = 0;
    found    = 1'b0;
    if (cmd == pjst_pkg::CMD_ADD) begin
      pr = (req < pjst_pkg::PRIO_MIN) ? pjst_pkg::PRIO_MIN :
           ((req > pjst_pkg::PRIO_MAX) ? pjst_pkg::PRIO_MAX : req[1:0]);
      for (i = 0; i < SLOTS && !found; i++) begin
        if (job_state_q[i] == pjst_pkg::SLOT_EMPTY ||
            job_state_q[i] == pjst_pkg::SLOT_REMOVED) begin
          found = 1'b1;
          job_state_q[i] = pjst_pkg::SLOT_PENDING;
          job_prio_q[i]  = pr;
          if (i + 1 > high_water_q) high_water_q = i + 1;
          r.slot = 7'(i);
          r.st   = pjst_pkg::SLOT_PENDING;
          r.prio = pr;
        end
      end
      if (!found) r.status = pjst_pkg::STATUS_FULL;
    end else if (cmd == pjst_pkg::CMD_DISPATCH) begin
      for (i = 0; i < high_water_q && i < SLOTS; i++) begin
        if (job_state_q[i] == pjst_pkg::SLOT_PENDING &&
            (!found || job_prio_q[i] > job_prio_q[best])) begin
          best  = i;
          found = 1'b1;
        end
      end
      if (found) begin
        job_state_q[best] = pjst_pkg::SLOT_RUNNING;
        r.slot = 7'(best);
        r.st   = pjst_pkg::SLOT_RUNNING;
        r.prio = job_prio_q[best];
      end else begin
        r.status = pjst_pkg::STATUS_NONE;
      end
    end else if (id >= high_water_q || id >= SLOTS) begin
      r.status = pjst_pkg::STATUS_BAD_ID;
      r.slot   = id;
    end else begin
      st = job_state_q[id];
      case (cmd)
        pjst_pkg::CMD_COMPLETE: if (st != pjst_pkg::SLOT_REMOVED) st = pjst_pkg::SLOT_DONE;
        pjst_pkg::CMD_SUSPEND:  if (st == pjst_pkg::SLOT_RUNNING) st = pjst_pkg::SLOT_SUSPENDED;
        pjst_pkg::CMD_RESUME:   if (st == pjst_pkg::SLOT_SUSPENDED) st = pjst_pkg::SLOT_RUNNING;
        pjst_pkg::CMD_REMOVE:   st = pjst_pkg::SLOT_REMOVED;
        default: ;
      endcase
      job_state_q[id] = st;
      r.slot = id;
      r.st   = st;
      r.prio = job_prio_q[id];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    job_result_t want;
    if (rst) begin
      for (int k = 0; k < SLOTS; k++) begin
        job_state_q[k] = pjst_pkg::SLOT_EMPTY;
        job_prio_q[k]  = '0;
      end
      high_water_q = 0;
      awaited_results.delete();
      fail_count = 0;
    end else begin
      // The result leaving now belongs to an earlier item, so check before predicting.
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result at %0t: status_code %0d result_slot %0d",
                     $time, status_code, result_slot);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (status_code !== want.status || result_slot !== want.slot ||
              slot_state !== want.st || slot_priority !== want.prio) begin
            if (fail_count < 10)
              $display({"mismatch at %0t: expected status_code %0d result_slot %0d ",
                        "slot_state %0d slot_priority %0d, got %0d %0d %0d %0d"},
                       $time, want.status, want.slot, want.st, want.prio,
                       status_code, result_slot, slot_state, slot_priority);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(next_table_result(command, slot_id, requested_priority));
    end
    outstanding = awaited_results.size();
  end

endmodule

// ----- verif/tb_priority_job_slot_table_core.sv -----
// Testbench top for the priority job slot table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_priority_job_slot_table_core;

  // The command field has one code beyond query; the block treats it as a query.
  localparam logic [2:0] CMD_SPARE = 3'd7;

  // An add or a dispatch scans the slot memory up to the high-water mark, and a held result
  // can add a long stall. Several times the worst gap between handshakes is allowed.
  localparam int WATCHDOG_LIMIT = 5000;

  // Roughly a quarter of the random stimulus goes into each idling phase.
  localparam int ITEMS_PER_PHASE = 320;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] command = pjst_pkg::CMD_QUERY;
  logic [6:0] slot_id = '0;
  logic [3:0] requested_priority = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] status_code;
  logic [6:0] result_slot;
  logic [2:0] slot_state;
  logic [1:0] slot_priority;

  int fail_count;
  int outstanding;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int adds_sent      = 0;
  int quiet_cycles   = 0;
  logic [6:0] last_result_slot = '0;

  priority_job_slot_table_core dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .command            (command),
    .slot_id            (slot_id),
    .requested_priority (requested_priority),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .status_code        (status_code),
    .result_slot        (result_slot),
    .slot_state         (slot_state),
    .slot_priority      (slot_priority)
  );

  pjst_result_checker u_result_checker (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .command            (command),
    .slot_id            (slot_id),
    .requested_priority (requested_priority),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .status_code        (status_code),
    .result_slot        (result_slot),
    .slot_state         (slot_state),
    .slot_priority      (slot_priority),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random with the rate of the current phase. It changes only
  // on the falling edge, so the block sees a settled value at every rising edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // The slot of the last result taken is kept so that, after a dispatch, a job's
  // lifecycle can follow it with suspend, resume and complete.
  always @(posedge clk) begin
    if (out_valid && !out_stall) last_result_slot <= result_slot;
  end

  // The watchdog counts cycles with no handshake on either channel. A hung block
  // ends the run here with the failure verdict.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Offers one item and returns at the falling edge after it was accepted. Valid is
  // left high so that a following item can go out back to back; whoever comes next
  // either drives a new item or lowers valid, and only once in that time step.
  task automatic send_item(input logic [2:0] cmd, input logic [6:0] id,
                           input logic [3:0] req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    command            <= cmd;
    slot_id            <= id;
    requested_priority <= req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
    if (cmd == pjst_pkg::CMD_ADD) adds_sent++;
  endtask

  // Slot ids are drawn mostly at or below the number of adds so far, which bounds the
  // high-water mark, so most slot commands hit a live slot and some hit a bad id.
  function automatic logic [6:0] pick_slot();
    int span;
    span = (adds_sent > 127) ? 127 : adds_sent;
    if ($urandom_range(9) == 0) return 7'($urandom_range(127));
    return 7'($urandom_range(span));
  endfunction

  task automatic send_random_item();
    int pick;
    logic [2:0] cmd;
    pick = $urandom_range(99);
    if (pick < 28)      cmd = pjst_pkg::CMD_ADD;
    else if (pick < 46) cmd = pjst_pkg::CMD_DISPATCH;
    else if (pick < 58) cmd = pjst_pkg::CMD_COMPLETE;
    else if (pick < 68) cmd = pjst_pkg::CMD_SUSPEND;
    else if (pick < 78) cmd = pjst_pkg::CMD_RESUME;
    else if (pick < 88) cmd = pjst_pkg::CMD_REMOVE;
    else if (pick < 97) cmd = pjst_pkg::CMD_QUERY;
    else                cmd = CMD_SPARE;
    send_item(cmd, pick_slot(), 4'($urandom_range(15)));
  endtask

  // A well-formed job lifecycle: add a job, dispatch, wait for the dispatched slot,
  // then suspend and resume it and finish it with complete or remove. Valid is
  // dropped while the dispatch result is awaited; the loop always waits for a falling
  // edge first so that valid is not driven twice in one time step.
  task automatic run_job_lifecycle();
    logic [6:0] job;
    send_item(pjst_pkg::CMD_ADD, pick_slot(), 4'($urandom_range(15)));
    send_item(pjst_pkg::CMD_DISPATCH, pick_slot(), 4'($urandom_range(15)));
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    job = last_result_slot;
    send_item(pjst_pkg::CMD_SUSPEND, job, 4'($urandom_range(15)));
    if ($urandom_range(1)) send_item(pjst_pkg::CMD_QUERY, job, 4'($urandom_range(15)));
    send_item(pjst_pkg::CMD_RESUME, job, 4'($urandom_range(15)));
    if ($urandom_range(1)) begin
      send_item(pjst_pkg::CMD_SUSPEND, job, 4'($urandom_range(15)));
      send_item(pjst_pkg::CMD_RESUME, job, 4'($urandom_range(15)));
    end
    send_item($urandom_range(3) == 0 ? pjst_pkg::CMD_REMOVE : pjst_pkg::CMD_COMPLETE, job,
              4'($urandom_range(15)));
  endtask

  initial begin
    int phase_start;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening on an empty table: nothing to dispatch, every slot id is bad,
    // then a few adds that exercise the priority clamp at both ends.
    send_item(pjst_pkg::CMD_DISPATCH, 7'd0, 4'd0);
    send_item(pjst_pkg::CMD_QUERY, 7'd0, 4'd0);
    send_item(pjst_pkg::CMD_COMPLETE, 7'd127, 4'd15);
    send_item(pjst_pkg::CMD_ADD, 7'd127, 4'd0);
    send_item(pjst_pkg::CMD_ADD, 7'd0, 4'd15);
    send_item(pjst_pkg::CMD_ADD, 7'd0, 4'd2);
    send_item(pjst_pkg::CMD_ADD, 7'd0, 4'd3);
    // The spare command code reads back like a query.
    send_item(CMD_SPARE, 7'd2, 4'd0);
    // Slot 4 sits exactly at the high-water mark and must be rejected.
    send_item(pjst_pkg::CMD_QUERY, 7'd4, 4'd0);
    // Slots 1 and 3 tie on the top priority; the lower index wins first.
    send_item(pjst_pkg::CMD_DISPATCH, 7'd0, 4'd0);
    send_item(pjst_pkg::CMD_DISPATCH, 7'd0, 4'd0);
    send_item(pjst_pkg::CMD_SUSPEND, 7'd1, 4'd0);
    // Suspend of a pending slot and resume of a non-suspended slot change nothing; slot 1 resumes.
    send_item(pjst_pkg::CMD_SUSPEND, 7'd0, 4'd0);
    send_item(pjst_pkg::CMD_RESUME, 7'd0, 4'd0);
    send_item(pjst_pkg::CMD_RESUME, 7'd1, 4'd0);
    // Complete works straight from pending.
    send_item(pjst_pkg::CMD_COMPLETE, 7'd0, 4'd0);
    // A removed slot stays removed under complete and suspend.
    send_item(pjst_pkg::CMD_REMOVE, 7'd3, 4'd0);
    send_item(pjst_pkg::CMD_COMPLETE, 7'd3, 4'd0);
    send_item(pjst_pkg::CMD_SUSPEND, 7'd3, 4'd0);
    // The removed slot is the first free one, so the next add reuses it.
    send_item(pjst_pkg::CMD_ADD, 7'd0, 4'd1);
    send_item(pjst_pkg::CMD_REMOVE, 7'd2, 4'd0);
    send_item(pjst_pkg::CMD_DISPATCH, 7'd0, 4'd0);
    send_item(pjst_pkg::CMD_DISPATCH, 7'd0, 4'd0);
    send_item(pjst_pkg::CMD_QUERY, 7'd1, 4'd0);
    send_item(pjst_pkg::CMD_COMPLETE, 7'd1, 4'd0);

    // Random part in four idling phases: none, sender idle half the time, receiver
    // stalling half the time, and both at a fifth.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      phase_start = items_sent;
      // One phase fills the table outright so that adds run into a full table.
      if (phase == 2)
        repeat (135) send_item(pjst_pkg::CMD_ADD, pick_slot(), 4'($urandom_range(15)));
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 25) run_job_lifecycle();
        else send_random_item();
      end
    end

    // Drain: wait for every outstanding result, then give the block time to show
    // any result nobody asked for.
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (300) @(negedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- priority_job_slot_table_core.f -----
design/pjst_pkg.sv
design/pjst_pick_unit.sv
design/priority_job_slot_table_core.sv
design/pjst_checker.sv
verif/pjst_result_checker.sv
verif/tb_priority_job_slot_table_core.sv
